>>> hw/rtl/rfae_pkg.sv
`timescale 1ns / 1ps

package rfae_pkg;

	// register file geometry
	localparam int NUM_REGS   = 32;
	localparam int REG_ADDR_W = $clog2(NUM_REGS);
	localparam int REG_IDX_W  = 5;
	localparam int DATA_W     = 32;
	localparam int MODE_W     = 4;
	localparam int CNT_W      = $clog2(DATA_W);

	// operation codes as carried in the mode field
	typedef enum logic [MODE_W-1:0] {
		OP_ADD  = 4'd0,
		OP_ADDI = 4'd1,
		OP_SUB  = 4'd2,
		OP_MUL  = 4'd3,
		OP_DIV  = 4'd4,
		OP_AND  = 4'd5,
		OP_ANDI = 4'd6,
		OP_OR   = 4'd7,
		OP_ORI  = 4'd8,
		OP_XOR  = 4'd9,
		OP_XORI = 4'd10,
		OP_NOR  = 4'd11,
		OP_J    = 4'd12
	} op_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [REG_IDX_W-1:0]     dest_reg;
		logic [REG_IDX_W-1:0]     src1_reg;
		logic [REG_IDX_W-1:0]     src2_reg;
		logic signed [DATA_W-1:0] immediate;
	} cmd_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic signed [DATA_W-1:0] first_source_value;
		logic signed [DATA_W-1:0] second_source_value;
		logic                     divide_error;
	} rsp_word_t;

	// register number lies inside the file
	function automatic logic idx_ok(input logic [REG_IDX_W-1:0] idx);
		return {{(32-REG_IDX_W){1'b0}}, idx} < 32'(NUM_REGS);
	endfunction

	function automatic logic [REG_ADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
		return REG_ADDR_W'(idx);
	endfunction

endpackage

>>> hw/rtl/rfae_if.sv
`timescale 1ns / 1ps

// command channel: one decoded instruction per word
interface rfae_cmd_if;
	logic               valid;
	logic               ready;
	rfae_pkg::cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// response channel: one result word per instruction
interface rfae_rsp_if;
	logic               valid;
	logic               ready;
	rfae_pkg::rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rfae_ram.sv
`timescale 1ns / 1ps

// simple dual port RAM, one write and one registered read port
module rfae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/register_file_alu_execute_top.sv
`timescale 1ns / 1ps

// channel | dir | word       | fields
// cmd     | in  | cmd_word_t | mode, dest_reg, src1_reg, src2_reg, immediate
// rsp     | out | rsp_word_t | result_value, first_source_value,
//         |     |            | second_source_value, divide_error
//
// One instruction at a time. Three reads through the single RAM read port
// (src1, src2, dest) then execute: ADD/SUB/logic/J finish in the execute state,
// MUL runs shift-add (one bit a cycle on the shared adder), DIV runs two sign
// fixes, 32 restoring steps and a final negate on the same adder.
// Reset clears the per-register valid bits, so every register reads zero.
// A finished result waiting on the output slot keeps done set; cmd ready stays low.

module register_file_alu_execute_top (
	input  logic        clk,
	input  logic        arst_n,
	rfae_cmd_if.sink    cmd,
	rfae_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDB,
		S_RDD,
		S_EXEC,
		S_MUL,
		S_ABSB,
		S_DIV,
		S_SIGN
	} state_t;

	state_t                              state_q;
	logic                                done_q;
	rfae_pkg::op_t                       op_q;
	logic [rfae_pkg::REG_IDX_W-1:0]      dst_q;
	logic [rfae_pkg::REG_IDX_W-1:0]      src2_q;
	logic [rfae_pkg::DATA_W-1:0]         x_q;
	logic [rfae_pkg::DATA_W-1:0]         y_q;
	logic [rfae_pkg::DATA_W-1:0]         acc_q;
	logic [rfae_pkg::DATA_W-1:0]         shf_q;
	logic [rfae_pkg::DATA_W-1:0]         res_q;
	logic [rfae_pkg::DATA_W-1:0]         src1_val_q;
	logic [rfae_pkg::DATA_W-1:0]         src2_val_q;
	logic [rfae_pkg::CNT_W-1:0]          cnt_q;
	logic                                neg_q;
	logic                                wr_q;
	logic                                err_q;
	logic                                rd_ok_q;
	logic [rfae_pkg::NUM_REGS-1:0]       vld_q;
	logic                                out_vld_q;
	rfae_pkg::rsp_word_t                 out_q;

	logic                                cmd_acc;
	logic                                rd_en;
	logic [rfae_pkg::REG_IDX_W-1:0]      rd_idx;
	logic [rfae_pkg::REG_ADDR_W-1:0]     rd_addr;
	logic [rfae_pkg::DATA_W-1:0]         ram_rdata;
	logic [rfae_pkg::DATA_W-1:0]         rdval;
	logic                                can_load;
	logic                                ram_we;
	logic [rfae_pkg::REG_ADDR_W-1:0]     ram_waddr;
	logic [rfae_pkg::DATA_W:0]           add_x;
	logic [rfae_pkg::DATA_W:0]           add_y;
	logic                                add_sub;
	logic [rfae_pkg::DATA_W+1:0]         add_sum;
	logic                                add_ge;
	logic [rfae_pkg::DATA_W-1:0]         mul_acc;
	logic                                is_imm;

	assign cmd.ready = (state_q == S_IDLE) && !done_q;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// read port sequencing: src1 at accept, then src2, then dest
	always_comb begin
		rd_en  = 1'b0;
		rd_idx = cmd.data.src1_reg;
		unique case (state_q)
			S_IDLE: begin
				rd_en  = cmd_acc;
				rd_idx = cmd.data.src1_reg;
			end
			S_RDB: begin
				rd_en  = 1'b1;
				rd_idx = src2_q;
			end
			S_RDD: begin
				rd_en  = 1'b1;
				rd_idx = dst_q;
			end
			default: begin
				rd_en  = 1'b0;
				rd_idx = dst_q;
			end
		endcase
	end

	assign rd_addr = rfae_pkg::reg_addr(rd_idx);
	assign rdval   = rd_ok_q ? ram_rdata : '0;

	// final word leaves when the output slot is free
	assign can_load  = done_q && (!out_vld_q || rsp.ready);
	assign ram_waddr = rfae_pkg::reg_addr(dst_q);
	assign ram_we    = can_load && wr_q && rfae_pkg::idx_ok(dst_q);

	rfae_ram #(
		.WIDTH (rfae_pkg::DATA_W),
		.DEPTH (rfae_pkg::NUM_REGS)
	) u_regs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (res_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// shared adder operand selection
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == rfae_pkg::OP_DIV) begin
					add_y   = {1'b0, x_q};
					add_sub = 1'b1;
				end else begin
					add_x   = {1'b0, x_q};
					add_y   = {1'b0, y_q};
					add_sub = (op_q == rfae_pkg::OP_SUB);
				end
			end
			S_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = {1'b0, x_q};
			end
			S_ABSB: begin
				add_y   = {1'b0, y_q};
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_x   = {acc_q, shf_q[rfae_pkg::DATA_W-1]};
				add_y   = {1'b0, y_q};
				add_sub = 1'b1;
			end
			S_SIGN: begin
				add_y   = {1'b0, shf_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ {{(rfae_pkg::DATA_W+1){1'b0}}, add_sub};
	// carry out on subtract means no borrow
	assign add_ge  = add_sum[rfae_pkg::DATA_W+1];
	assign mul_acc = shf_q[0] ? add_sum[rfae_pkg::DATA_W-1:0] : acc_q;

	assign is_imm = (op_q == rfae_pkg::OP_ADDI) || (op_q == rfae_pkg::OP_ANDI)
		|| (op_q == rfae_pkg::OP_ORI) || (op_q == rfae_pkg::OP_XORI);

	// sequencer, datapath registers and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			op_q       <= rfae_pkg::OP_J;
			dst_q      <= '0;
			src2_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			acc_q      <= '0;
			shf_q      <= '0;
			res_q      <= '0;
			src1_val_q <= '0;
			src2_val_q <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			wr_q       <= 1'b0;
			err_q      <= 1'b0;
			rd_ok_q    <= 1'b0;
			vld_q      <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			if (rd_en) begin
				rd_ok_q <= rfae_pkg::idx_ok(rd_idx) && vld_q[rd_addr];
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (can_load) begin
				out_vld_q                 <= 1'b1;
				out_q.result_value        <= res_q;
				out_q.first_source_value  <= src1_val_q;
				out_q.second_source_value <= src2_val_q;
				out_q.divide_error        <= err_q;
				done_q                    <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q    <= rfae_pkg::op_t'(cmd.data.mode);
						dst_q   <= cmd.data.dest_reg;
						src2_q  <= cmd.data.src2_reg;
						y_q     <= cmd.data.immediate;
						wr_q    <= 1'b0;
						err_q   <= 1'b0;
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					src1_val_q <= rdval;
					x_q        <= rdval;
					state_q    <= S_RDD;
				end
				S_RDD: begin
					src2_val_q <= rdval;
					if (!is_imm) begin
						y_q <= rdval;
					end
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					// old dest value stands unless a write replaces it
					res_q   <= rdval;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					unique case (op_q)
						rfae_pkg::OP_ADD, rfae_pkg::OP_ADDI, rfae_pkg::OP_SUB: begin
							res_q <= add_sum[rfae_pkg::DATA_W-1:0];
							wr_q  <= 1'b1;
						end
						rfae_pkg::OP_AND, rfae_pkg::OP_ANDI: begin
							res_q <= x_q & y_q;
							wr_q  <= 1'b1;
						end
						rfae_pkg::OP_OR, rfae_pkg::OP_ORI: begin
							res_q <= x_q | y_q;
							wr_q  <= 1'b1;
						end
						rfae_pkg::OP_XOR, rfae_pkg::OP_XORI: begin
							res_q <= x_q ^ y_q;
							wr_q  <= 1'b1;
						end
						rfae_pkg::OP_NOR: begin
							res_q <= ~(x_q | y_q);
							wr_q  <= 1'b1;
						end
						rfae_pkg::OP_MUL: begin
							acc_q   <= '0;
							shf_q   <= y_q;
							cnt_q   <= '1;
							state_q <= S_MUL;
							done_q  <= 1'b0;
						end
						rfae_pkg::OP_DIV: begin
							if (y_q == '0) begin
								err_q <= 1'b1;
							end else begin
								shf_q   <= x_q[rfae_pkg::DATA_W-1] ?
									add_sum[rfae_pkg::DATA_W-1:0] : x_q;
								neg_q   <= x_q[rfae_pkg::DATA_W-1] ^
									y_q[rfae_pkg::DATA_W-1];
								state_q <= S_ABSB;
								done_q  <= 1'b0;
							end
						end
						default: begin
							// jump and unused codes: no write
							wr_q <= 1'b0;
						end
					endcase
				end
				S_MUL: begin
					acc_q <= mul_acc;
					x_q   <= {x_q[rfae_pkg::DATA_W-2:0], 1'b0};
					shf_q <= {1'b0, shf_q[rfae_pkg::DATA_W-1:1]};
					cnt_q <= cnt_q - rfae_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						res_q   <= mul_acc;
						wr_q    <= 1'b1;
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_ABSB: begin
					y_q     <= y_q[rfae_pkg::DATA_W-1] ?
						add_sum[rfae_pkg::DATA_W-1:0] : y_q;
					acc_q   <= '0;
					cnt_q   <= '1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring step: one quotient bit
					acc_q <= add_ge ? add_sum[rfae_pkg::DATA_W-1:0] :
						add_x[rfae_pkg::DATA_W-1:0];
					shf_q <= {shf_q[rfae_pkg::DATA_W-2:0], add_ge};
					cnt_q <= cnt_q - rfae_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					res_q   <= neg_q ? add_sum[rfae_pkg::DATA_W-1:0] : shf_q;
					wr_q    <= 1'b1;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// register writes only come from a finished computing instruction
	a_we_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (done_q && wr_q && !err_q))
		else $error("register write outside completion");

	// a written register reads back as valid afterwards
	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> vld_q[$past(ram_waddr)])
		else $error("valid bit not set after write");

	// last restoring step hands over to the sign fix
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> (state_q == S_SIGN))
		else $error("divide sequence did not end");

	// divide error only ever reported for a divide
	a_err_op: assert property (@(posedge clk) disable iff (!arst_n)
		(can_load && err_q) |-> (op_q == rfae_pkg::OP_DIV && !wr_q))
		else $error("divide error on wrong operation");
`endif

endmodule

>>> tb/sv/tb_register_file_alu_execute_top.sv
`timescale 1ns / 1ps

module tb_register_file_alu_execute_top;
	import rfae_pkg::*;

	localparam int RANDOM_WORDS = 1600;
	localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
	localparam int HOLD_AFTER   = 600;   // words accepted before the hold-off
	localparam int DRAIN_CYCLES = 60;    // slowest instruction is DIV
	localparam int CYCLE_LIMIT  = 600000;

	// spare mode codes, executed as J
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = OP_J + 4'd1;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID   = OP_J + 4'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

	typedef struct {
		cmd_word_t c;
		bit        typed;
		rsp_word_t r;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rfae_cmd_if cmd_ch ();
	rfae_rsp_if rsp_ch ();

	register_file_alu_execute_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the register file, updated on every accepted word
	logic [DATA_W-1:0] shadow_regs [NUM_REGS];
	rsp_word_t         pending_results [$];
	dir_row_t          dir_rows [$];

	int failures        = 0;
	int words_sent      = 0;
	int results_checked = 0;
	int div_zero_seen   = 0;
	int spare_seen      = 0;
	int cycle_count     = 0;
	int burst_left      = 1;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// register read as the block does it: out of range reads as zero
	function automatic logic [DATA_W-1:0] read_shadow(input logic [REG_IDX_W-1:0] idx);
		if (int'(idx) < NUM_REGS) begin
			return shadow_regs[idx];
		end
		return '0;
	endfunction

	// execute one instruction against the shadow file, return its response
	function automatic rsp_word_t execute_instr(input cmd_word_t c);
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic [DATA_W-1:0] quot;
		bit                writes;
		bit                dz;
		rsp_word_t         o;
		a      = read_shadow(c.src1_reg);
		b      = read_shadow(c.src2_reg);
		r      = '0;
		writes = 1'b1;
		dz     = 1'b0;
		case (c.mode)
			OP_ADD:  r = a + b;
			OP_ADDI: r = a + c.immediate;
			OP_SUB:  r = a - b;
			OP_MUL:  r = a * b;
			OP_DIV: begin
				if (b == '0) begin
					writes = 1'b0;
					dz     = 1'b1;
				end else begin
					// divide magnitudes, then restore the sign (truncates toward zero)
					mag_a = a[DATA_W-1] ? -a : a;
					mag_b = b[DATA_W-1] ? -b : b;
					quot  = mag_a / mag_b;
					r     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
				end
			end
			OP_AND:  r = a & b;
			OP_ANDI: r = a & c.immediate;
			OP_OR:   r = a | b;
			OP_ORI:  r = a | c.immediate;
			OP_XOR:  r = a ^ b;
			OP_XORI: r = a ^ c.immediate;
			OP_NOR:  r = ~(a | b);
			default: writes = 1'b0;
		endcase
		if (!writes) begin
			r = read_shadow(c.dest_reg);
		end else if (int'(c.dest_reg) < NUM_REGS) begin
			shadow_regs[c.dest_reg] = r;
		end
		o.result_value        = r;
		o.first_source_value  = a;
		o.second_source_value = b;
		o.divide_error        = dz;
		return o;
	endfunction

	function automatic void add_row(input logic [MODE_W-1:0] m, input int d, input int s1,
			input int s2, input logic [DATA_W-1:0] imm, input bit typed,
			input logic [DATA_W-1:0] rv = '0, input logic [DATA_W-1:0] av = '0,
			input logic [DATA_W-1:0] bv = '0, input bit err = 1'b0);
		dir_row_t row;
		row.c.mode                = m;
		row.c.dest_reg            = REG_IDX_W'(d);
		row.c.src1_reg            = REG_IDX_W'(s1);
		row.c.src2_reg            = REG_IDX_W'(s2);
		row.c.immediate           = imm;
		row.typed                 = typed;
		row.r.result_value        = rv;
		row.r.first_source_value  = av;
		row.r.second_source_value = bv;
		row.r.divide_error        = err;
		dir_rows = {dir_rows, row};
	endfunction

	// operands lean towards the awkward values: extremes, small and zero
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return DATA_W'(int'($urandom_range(0, 16)) - 8);
			2: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return '1;
					2: return 32'h7FFF_FFFF;
					3: return 32'h8000_0000;
					default: return 32'd1;
				endcase
			end
			default: return '0;
		endcase
	endfunction

	// low registers 0 to 3 get extra traffic so results feed back
	function automatic logic [REG_IDX_W-1:0] pick_reg();
		if ($urandom_range(0, 9) < 3) begin
			return REG_IDX_W'($urandom_range(0, 3));
		end
		return REG_IDX_W'($urandom_range(0, 31));
	endfunction

	function automatic cmd_word_t rand_instr();
		cmd_word_t w;
		w.mode      = MODE_W'($urandom_range(0, 15));
		w.dest_reg  = pick_reg();
		w.src1_reg  = pick_reg();
		w.src2_reg  = pick_reg();
		w.immediate = pick_operand();
		return w;
	endfunction

	// offer one word, wait for acceptance, log its expected response
	task automatic offer_word(input cmd_word_t w, input bit typed, input rsp_word_t typed_rsp);
		rsp_word_t predicted;
		int        gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= w;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		predicted = execute_instr(w);
		if (typed) begin
			predicted = typed_rsp;
		end
		pending_results = {pending_results, predicted};
		words_sent++;
		if (w.mode > OP_J) begin
			spare_seen++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 8);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				cmd_ch.data  <= rand_instr();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// response side: runs of always-ready, coin-toss and stall, plus one long hold-off
	initial begin : rsp_drive
		int  kind;
		int  run_len;
		bit  held;
		held         = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && words_sent >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			kind    = $urandom_range(0, 2);
			run_len = $urandom_range(1, 40);
			for (int i = 0; i < run_len; i++) begin
				case (kind)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= (i < run_len / 2) ? 1'b0 : 1'b1;
				endcase
				@(posedge clk);
			end
		end
	end

	// compare each accepted response word with the oldest expectation
	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: response with nothing expected: got %h", $time, rsp_ch.data);
				failures++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.data.divide_error) begin
					div_zero_seen++;
				end
				if (rsp_ch.data.result_value !== want.result_value) begin
					$display("%0t: result_value expected %h got %h", $time,
						want.result_value, rsp_ch.data.result_value);
					failures++;
				end
				if (rsp_ch.data.first_source_value !== want.first_source_value) begin
					$display("%0t: first_source_value expected %h got %h", $time,
						want.first_source_value, rsp_ch.data.first_source_value);
					failures++;
				end
				if (rsp_ch.data.second_source_value !== want.second_source_value) begin
					$display("%0t: second_source_value expected %h got %h", $time,
						want.second_source_value, rsp_ch.data.second_source_value);
					failures++;
				end
				if (rsp_ch.data.divide_error !== want.divide_error) begin
					$display("%0t: divide_error expected %b got %b", $time,
						want.divide_error, rsp_ch.data.divide_error);
					failures++;
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
			cycle_count, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main_seq
		rsp_word_t none;
		none = '0;
		foreach (shadow_regs[i]) begin
			shadow_regs[i] = '0;
		end
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;

		// directed words; register file is all zero out of reset
		add_row(OP_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h0, 32'h0);
		add_row(OP_ADDI, 2, 0, 1, 32'h8000_0000, 1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		add_row(OP_ADDI, 3, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h0, 32'h0);
		// divide by zero leaves r4 alone
		add_row(OP_DIV, 4, 1, 5, 32'h0, 1, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1);
		// most negative over minus one wraps
		add_row(OP_DIV, 6, 2, 3, 32'h0, 1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		add_row(OP_ADD, 7, 1, 1, 32'h0, 1, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(OP_SUB, 8, 2, 1, 32'h0, 1, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
		add_row(OP_MUL, 9, 1, 1, 32'h0, 1, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(OP_MUL, 10, 2, 3, 32'h0, 0);
		add_row(OP_DIV, 11, 3, 1, 32'h0, 0);
		add_row(OP_DIV, 20, 2, 1, 32'h0, 0);
		add_row(OP_DIV, 19, 7, 3, 32'h0, 0);
		add_row(OP_AND, 12, 1, 3, 32'h0, 0);
		add_row(OP_ANDI, 13, 3, 0, 32'h0F0F_0F0F, 0);
		add_row(OP_OR, 14, 1, 2, 32'h0, 0);
		add_row(OP_ORI, 15, 0, 0, 32'hA5A5_A5A5, 0);
		add_row(OP_XOR, 16, 3, 1, 32'h0, 0);
		add_row(OP_XORI, 17, 1, 0, 32'h5A5A_5A5A, 0);
		add_row(OP_NOR, 18, 0, 0, 32'h0, 0);
		// J and spare codes write nothing and report the old destination
		add_row(OP_J, 1, 2, 3, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		add_row(MODE_SPARE_FIRST, 31, 1, 2, 32'h0, 1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		add_row(MODE_SPARE_MID, 2, 0, 31, 32'h0, 1, 32'h8000_0000, 32'h0, 32'h0);
		add_row(MODE_SPARE_LAST, 3, 3, 3, 32'h0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		// register 0 is an ordinary register
		add_row(OP_ADD, 0, 1, 3, 32'h0, 0);
		add_row(OP_DIV, 31, 0, 0, 32'h0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer_word(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
		end
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			offer_word(rand_instr(), 1'b0, none);
		end
		cmd_ch.valid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d instructions (%0d directed), %0d responses checked in %0d cycles",
			words_sent, dir_rows.size(), results_checked, cycle_count);
		$display("Saw %0d divide-by-zero responses and %0d spare-code no-ops; %0d mismatches",
			div_zero_seen, spare_seen, failures);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
